// ----- hdl/sps_pkg.sv -----
// Shared types and codes for the slotted page slot allocator.
// No dependencies; imported by every module of the block.
package sps_pkg;

	localparam int SIZE_W       = 14;
	localparam int PREFIX_BYTES = 2;

	localparam logic [2:0] OP_INIT        = 3'd0;
	localparam logic [2:0] OP_APPEND      = 3'd1;
	localparam logic [2:0] OP_INSERT_AT   = 3'd2;
	localparam logic [2:0] OP_SHIFT_LEFT  = 3'd3;
	localparam logic [2:0] OP_SHIFT_RIGHT = 3'd4;
	localparam logic [2:0] OP_REMOVE      = 3'd5;
	localparam logic [2:0] OP_LOOKUP      = 3'd6;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_BAD_IDX  = 2'd1;
	localparam logic [1:0] STAT_NO_SPACE = 2'd2;

	localparam logic KIND_MOVE = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	localparam logic [1:0] REG_FIXED_SIZE = 2'd0;
	localparam logic [1:0] REG_EXTRA_HDR  = 2'd1;

	typedef logic [2:0] cell_cmd_t;
	localparam cell_cmd_t CELL_HOLD  = 3'd0;
	localparam cell_cmd_t CELL_NEW   = 3'd1;
	localparam cell_cmd_t CELL_LEFT  = 3'd2;
	localparam cell_cmd_t CELL_RIGHT = 3'd3;
	localparam cell_cmd_t CELL_MOVE  = 3'd4;
	localparam cell_cmd_t CELL_CLRD  = 3'd5;

	typedef struct packed {
		logic [2:0]  operation;
		logic [5:0]  slot_index;
		logic [5:0]  end_index;
		logic [12:0] cell_bytes;
	} sps_in_t;

	typedef struct packed {
		logic        kind;
		logic [11:0] move_source;
		logic [11:0] move_dest;
		logic [12:0] move_length;
		logic [5:0]  result_slot;
		logic [11:0] data_offset;
		logic [5:0]  count_now;
		logic [1:0]  status;
		logic        last;
	} sps_out_t;

endpackage

// ----- hdl/slotted_page_slot_allocator.sv -----
// Top level of the slotted page slot allocator: control FSM and cell row.
// Depends on sps_pkg and sps_cell.
//
//  channel | signals                   | dir | moves
//  --------+---------------------------+-----+--------------------------------
//  req     | req_valid req_ready req   | in  | one operation per transfer
//  rsp     | rsp_valid rsp_ready rsp   | out | move commands, then a completion
//  cfg     | cfg_we cfg_index cfg_data | in  | register write, no handshake
//
// One operation at a time. Remove_range shifts the row down in S_REMOVE, once
// per removed slot. Compaction repeats a serial scan for the highest unvisited
// offset over the one read port of the row and emits one move per cell.
// Reset clears count, data top and marks; slot contents stay undefined.
// Output stalls hold the FSM where it loads a response; req_ready is high only in idle.
module slotted_page_slot_allocator import sps_pkg::*; #(
	parameter int PAGE_BYTES   = 4096,
	parameter int MAX_CELLS    = 32,
	parameter int HEADER_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  sps_in_t     req,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output sps_out_t    rsp,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	localparam int OFFW = $clog2(PAGE_BYTES + 1);
	localparam int CW   = $clog2(MAX_CELLS + 1);
	localparam int CIW  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int SUMW = ((OFFW > SIZE_W) ? OFFW : SIZE_W) + 3;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EXEC   = 3'd1;
	localparam logic [2:0] S_REMOVE = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_EMIT   = 3'd4;

	logic [2:0]        state_q;
	sps_in_t           req_q;
	logic [CW-1:0]     count_q;
	logic [OFFW-1:0]   top_q;      // data top
	logic [OFFW-1:0]   ctop_q;     // running top during compaction
	logic              compacted_q;
	logic [CW-1:0]     scan_q;
	logic [CW-1:0]     rounds_q;
	logic [CW-1:0]     rem_q;
	logic              found_q;
	logic [CIW-1:0]    best_q;
	logic [OFFW-1:0]   best_off_q;
	logic [SIZE_W-1:0] best_size_q;
	logic              rsp_valid_q;
	sps_out_t          rsp_q;
	sps_out_t          rsp_d;
	logic              rsp_fire;
	logic [12:0]       fixed_q;
	logic [8:0]        extra_q;

	// cell row
	logic [OFFW-1:0]   c_off  [MAX_CELLS];
	logic [SIZE_W-1:0] c_size [MAX_CELLS];
	logic              c_done [MAX_CELLS];
	cell_cmd_t         c_cmd  [MAX_CELLS];
	logic [OFFW-1:0]   cell_new_off;

	// decode of the held operation
	logic [2:0]        op;
	logic [5:0]        idx;
	logic [5:0]        cnt6;
	logic              is_ins;
	logic              bad_ins;
	logic              ow;
	logic              rm_ok;
	logic              cmp_go;
	logic [SIZE_W-1:0] prefix;
	logic [SIZE_W-1:0] asize;
	logic [SUMW-1:0]   need;
	logic              fits;
	logic              commit;
	logic [OFFW-1:0]   new_top;
	logic [CIW-1:0]    rd_addr;
	logic [OFFW-1:0]   rd_off;
	logic [SIZE_W-1:0] rd_size;
	logic              rd_done;
	logic [SIZE_W-1:0] mv_len;
	logic [OFFW-1:0]   mv_top;
	logic [5:0]        rm_len;

	assign op     = req_q.operation;
	assign cnt6   = 6'(count_q);
	assign idx    = (op == OP_APPEND) ? cnt6 : req_q.slot_index;
	assign is_ins = (op == OP_APPEND) || (op == OP_INSERT_AT) ||
	                (op == OP_SHIFT_LEFT) || (op == OP_SHIFT_RIGHT);
	assign bad_ins = ((op == OP_APPEND) || (op == OP_INSERT_AT)) ?
	                 ((count_q >= CW'(MAX_CELLS)) || (idx > cnt6)) : (idx >= cnt6);
	assign ow     = !rsp_valid_q || rsp_ready;
	assign rm_len = req_q.end_index - req_q.slot_index;

	// valid range removal, and an insert that must compact first
	assign rm_ok  = (op == OP_REMOVE) && (req_q.slot_index <= req_q.end_index) &&
	                (req_q.end_index <= cnt6);
	assign cmp_go = is_ins && !bad_ins && !fits && !compacted_q;

	// length prefix only in variable size mode
	assign prefix = (fixed_q == 13'd0) ? SIZE_W'(PREFIX_BYTES) : '0;
	assign asize  = SIZE_W'(req_q.cell_bytes) + prefix;
	assign need   = SUMW'(HEADER_BYTES) + SUMW'(extra_q) +
	                (SUMW'(count_q) + SUMW'(1)) * SUMW'(PREFIX_BYTES) + SUMW'(asize);
	assign fits   = SUMW'(top_q) >= need;
	assign new_top = OFFW'(SUMW'(top_q) - SUMW'(asize));

	assign commit = (state_q == S_EXEC) && ow && is_ins && !bad_ins && fits;

	// single read port of the row: scan pointer or the lookup index
	assign rd_addr = (state_q == S_SCAN) ? scan_q[CIW-1:0] : idx[CIW-1:0];
	assign rd_off  = c_off[rd_addr];
	assign rd_size = c_size[rd_addr];
	assign rd_done = c_done[rd_addr];

	// compaction move: length and saturating new top
	assign mv_len = (fixed_q != 13'd0) ? SIZE_W'(fixed_q) : best_size_q;
	always_comb begin
		if (SUMW'(ctop_q) > SUMW'(mv_len)) begin
			mv_top = OFFW'(SUMW'(ctop_q) - SUMW'(mv_len));
		end else begin
			mv_top = '0;
		end
	end

	assign cell_new_off = (state_q == S_EMIT) ? mv_top : new_top;

	// per cell command
	always_comb begin
		for (int k = 0; k < MAX_CELLS; k++) begin
			c_cmd[k] = CELL_HOLD;
			if (commit) begin
				if (k == int'(idx)) begin
					c_cmd[k] = CELL_NEW;
				end else if ((op == OP_APPEND) || (op == OP_INSERT_AT)) begin
					if (k > int'(idx) && k <= int'(count_q)) c_cmd[k] = CELL_LEFT;
				end else if (op == OP_SHIFT_LEFT) begin
					if (k < int'(idx)) c_cmd[k] = CELL_RIGHT;
				end else begin
					if (k > int'(idx) && k < int'(count_q)) c_cmd[k] = CELL_LEFT;
				end
			end else if (state_q == S_REMOVE && rem_q != '0) begin
				if (k >= int'(req_q.slot_index)) c_cmd[k] = CELL_RIGHT;
			end else if (state_q == S_EMIT && ow) begin
				if (k == int'(best_q)) c_cmd[k] = CELL_MOVE;
			end else if (state_q == S_EXEC && cmp_go) begin
				c_cmd[k] = CELL_CLRD;
			end
		end
	end

	for (genvar g = 0; g < MAX_CELLS; g++) begin : g_cell
		logic [OFFW-1:0]   l_off;
		logic [SIZE_W-1:0] l_size;
		logic [OFFW-1:0]   r_off;
		logic [SIZE_W-1:0] r_size;
		if (g == 0) begin : g_first
			assign l_off  = '0;
			assign l_size = '0;
		end else begin : g_mid_l
			assign l_off  = c_off[g-1];
			assign l_size = c_size[g-1];
		end
		if (g == MAX_CELLS - 1) begin : g_last
			assign r_off  = '0;
			assign r_size = '0;
		end else begin : g_mid_r
			assign r_off  = c_off[g+1];
			assign r_size = c_size[g+1];
		end
		sps_cell #(.OFFW(OFFW)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (c_cmd[g]),
			.new_off    (cell_new_off),
			.new_size   (asize),
			.left_off   (l_off),
			.left_size  (l_size),
			.right_off  (r_off),
			.right_size (r_size),
			.off        (c_off[g]),
			.size       (c_size[g]),
			.done       (c_done[g])
		);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_q <= '0;
			extra_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_FIXED_SIZE) fixed_q <= cfg_data;
			if (cfg_index == REG_EXTRA_HDR)  extra_q <= cfg_data[8:0];
		end
	end

	// next response word
	always_comb begin
		rsp_d.kind        = KIND_DONE;
		rsp_d.move_source = '0;
		rsp_d.move_dest   = '0;
		rsp_d.move_length = '0;
		rsp_d.result_slot = idx;
		rsp_d.data_offset = '0;
		rsp_d.count_now   = cnt6;
		rsp_d.status      = STAT_BAD_IDX;
		rsp_d.last        = 1'b1;
		priority case (state_q)
			S_EXEC: begin
				if (op == OP_INIT) begin
					rsp_d.result_slot = '0;
					rsp_d.count_now   = '0;
					rsp_d.status      = STAT_OK;
				end else if (op == OP_REMOVE) begin
					rsp_d.result_slot = req_q.slot_index;
				end else if (op == OP_LOOKUP) begin
					if (idx < cnt6) begin
						rsp_d.status      = STAT_OK;
						rsp_d.data_offset = 12'(SUMW'(rd_off) + SUMW'(prefix));
					end
				end else if (is_ins && !bad_ins) begin
					if (fits) begin
						rsp_d.status      = STAT_OK;
						rsp_d.data_offset = 12'(SUMW'(new_top) + SUMW'(prefix));
						if ((op == OP_APPEND) || (op == OP_INSERT_AT))
							rsp_d.count_now = 6'(count_q + CW'(1));
					end else begin
						rsp_d.status = STAT_NO_SPACE;
					end
				end
			end
			S_REMOVE: begin
				rsp_d.result_slot = req_q.slot_index;
				rsp_d.status      = STAT_OK;
				rsp_d.count_now   = cnt6 - rm_len;
			end
			S_EMIT: begin
				rsp_d.kind        = KIND_MOVE;
				rsp_d.move_source = 12'(best_off_q);
				rsp_d.move_dest   = 12'(mv_top);
				rsp_d.move_length = 13'(mv_len);
				rsp_d.result_slot = '0;
				rsp_d.status      = STAT_OK;
				rsp_d.last        = 1'b0;
			end
			default: rsp_d = rsp_q;
		endcase
	end

	// a new transfer is loaded into the output register
	always_comb begin
		unique case (state_q)
			S_EXEC:   rsp_fire = ow && !rm_ok && !cmp_go;
			S_REMOVE: rsp_fire = ow && (rem_q == '0);
			S_EMIT:   rsp_fire = ow;
			default:  rsp_fire = 1'b0;
		endcase
	end

	// payload of the held request and the response register
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) req_q <= req;
		if (ow) rsp_q <= rsp_d;
	end

	// scan payload and remove counter
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && scan_q < count_q && !rd_done &&
		    (!found_q || rd_off > best_off_q)) begin
			best_q      <= scan_q[CIW-1:0];
			best_off_q  <= rd_off;
			best_size_q <= rd_size;
		end
		if (state_q == S_EXEC) rem_q <= CW'(rm_len);
		else if (state_q == S_REMOVE && rem_q != '0) rem_q <= rem_q - CW'(1);
	end

	// control FSM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			top_q       <= OFFW'(PAGE_BYTES);
			ctop_q      <= '0;
			compacted_q <= 1'b0;
			scan_q      <= '0;
			rounds_q    <= '0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_fire) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						compacted_q <= 1'b0;
						state_q     <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (rm_ok) begin
						state_q <= S_REMOVE;
					end else if (cmp_go) begin
						ctop_q   <= OFFW'(PAGE_BYTES);
						rounds_q <= '0;
						scan_q   <= '0;
						found_q  <= 1'b0;
						state_q  <= S_SCAN;
					end else if (ow) begin
						state_q <= S_IDLE;
						if (op == OP_INIT) begin
							count_q <= '0;
							top_q   <= OFFW'(PAGE_BYTES);
						end else if (commit) begin
							top_q <= new_top;
							if ((op == OP_APPEND) || (op == OP_INSERT_AT))
								count_q <= count_q + CW'(1);
						end
					end
				end
				S_REMOVE: begin
					if (rem_q == '0 && ow) begin
						count_q <= count_q - CW'(rm_len);
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (scan_q < count_q) begin
						if (!rd_done && (!found_q || rd_off > best_off_q))
							found_q <= 1'b1;
						scan_q <= scan_q + CW'(1);
					end else if (found_q) begin
						state_q <= S_EMIT;
					end else begin
						top_q       <= ctop_q;
						compacted_q <= 1'b1;
						state_q     <= S_EXEC;
					end
				end
				S_EMIT: begin
					if (ow) begin
						ctop_q   <= mv_top;
						rounds_q <= rounds_q + CW'(1);
						found_q  <= 1'b0;
						scan_q   <= '0;
						if (rounds_q + CW'(1) == count_q) begin
							top_q       <= mv_top;
							compacted_q <= 1'b1;
							state_q     <= S_EXEC;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- hdl/sps_cell.sv -----
// One slot of the directory: cell offset, size and compaction mark.
// Depends on sps_pkg; a row of these forms the slot table.
module sps_cell import sps_pkg::*; #(
	parameter int OFFW = 13
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_cmd_t         cmd,
	input  logic [OFFW-1:0]   new_off,
	input  logic [SIZE_W-1:0] new_size,
	input  logic [OFFW-1:0]   left_off,
	input  logic [SIZE_W-1:0] left_size,
	input  logic [OFFW-1:0]   right_off,
	input  logic [SIZE_W-1:0] right_size,
	output logic [OFFW-1:0]   off,
	output logic [SIZE_W-1:0] size,
	output logic              done
);

	logic [OFFW-1:0]   off_q;
	logic [SIZE_W-1:0] size_q;
	logic              done_q;

	// payload, no reset
	always_ff @(posedge clk) begin
		unique case (cmd)
			CELL_NEW: begin
				off_q  <= new_off;
				size_q <= new_size;
			end
			CELL_LEFT: begin
				off_q  <= left_off;
				size_q <= left_size;
			end
			CELL_RIGHT: begin
				off_q  <= right_off;
				size_q <= right_size;
			end
			CELL_MOVE: off_q <= new_off;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else if (cmd == CELL_CLRD) begin
			done_q <= 1'b0;
		end else if (cmd == CELL_MOVE) begin
			done_q <= 1'b1;
		end
	end

	assign off  = off_q;
	assign size = size_q;
	assign done = done_q;

endmodule

// ----- hdl/sps_checker.sv -----
// Port-level checks for the slotted page slot allocator, bound to the top.
// Depends on sps_pkg and slotted_page_slot_allocator.
module sps_checker import sps_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_ready,
	input logic     rsp_valid,
	input logic     rsp_ready,
	input sps_out_t rsp
);

	// a move command never closes an operation and never carries an error
	a_move_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == KIND_MOVE |-> !rsp.last && rsp.status == STAT_OK)
		else $error("move command with last or status set");

	// a completion always closes the operation
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == KIND_DONE |-> rsp.last)
		else $error("completion without last");

	// one operation at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

endmodule

bind slotted_page_slot_allocator sps_checker u_sps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
